[design/iems_pkg.sv]
// Package with shared types and constants for the I2C EEPROM master sequencer.
`timescale 1ns / 1ps
package iems_pkg;

   localparam int ADDR_WIDTH = 16;

   localparam int REQ_DATA_WIDTH = 48;
   localparam int RSP_DATA_WIDTH = 16;
   localparam int CSR_ADDR_WIDTH = 2;
   localparam int CSR_DATA_WIDTH = 8;

   localparam logic [7:0] DEV_WRITE_ADDR_RESET = 8'hA8;
   localparam logic [7:0] DEV_READ_ADDR_RESET  = 8'hA9;
   localparam logic [3:0] BUSY_RELOAD_RESET    = 4'd10;

   localparam logic [3:0] BITS_PER_BYTE = 4'd8;

   typedef enum logic [CSR_ADDR_WIDTH-1:0] {
      CSR_DEV_WRITE_ADDR = 2'd0,
      CSR_DEV_READ_ADDR  = 2'd1,
      CSR_BUSY_RELOAD    = 2'd2,
      CSR_UNUSED         = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      OP_BUS_TICK    = 2'd0,
      OP_BEGIN_READ  = 2'd1,
      OP_BEGIN_WRITE = 2'd2,
      OP_MS_TICK     = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      MODE_NONE  = 2'd0,
      MODE_READ  = 2'd1,
      MODE_WRITE = 2'd2
   } mode_type;

   typedef enum logic [3:0] {
      PH_IDLE    = 4'd0,
      PH_START_A = 4'd1,
      PH_START_B = 4'd2,
      PH_DEVW    = 4'd3,
      PH_AHI     = 4'd4,
      PH_ALO     = 4'd5,
      PH_RST_A   = 4'd6,
      PH_RST_B   = 4'd7,
      PH_RST_C   = 4'd8,
      PH_RST_D   = 4'd9,
      PH_DEVR    = 4'd10,
      PH_RDATA   = 4'd11,
      PH_WDATA   = 4'd12,
      PH_STOP_A  = 4'd13,
      PH_STOP_B  = 4'd14
   } phase_type;

   typedef enum logic [1:0] {
      SUB_SET_SDA  = 2'd0,
      SUB_SCL_HIGH = 2'd1,
      SUB_SCL_LOW  = 2'd2
   } sub_type;

endpackage

[design/i2c_eeprom_master_sequencer_top.sv]
// I2C EEPROM master sequencer: random read and page write driven by bus ticks.
// Each response beat is registered and appears in the cycle after its request beat is accepted.
// Throughput: one beat per cycle; the whole tick step sits between the request
// handshake and the response register, and the next beat is taken while a
// response waits as long as the response side is ready in the same cycle.
// Reset: synchronous, active high; idle phase, lines released, registers at defaults.
`timescale 1ns / 1ps
module i2c_eeprom_master_sequencer_top
   import iems_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // mem_address[15:0], length[31:16], write_data[39:32], sda_in[40], zero[47:41]
   input  logic [REQ_DATA_WIDTH-1:0] req_tdata,
   // op[1:0]
   input  logic [1:0]                req_tuser,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // scl_level[0], sda_level[1], read_byte[9:2], read_valid[10], data_taken[11],
   // done_res[12], status[13], device_busy[14], zero[15]
   output logic [RSP_DATA_WIDTH-1:0] rsp_tdata,
   input  logic                      csr_we,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_addr,
   input  logic [CSR_DATA_WIDTH-1:0] csr_wdata
);

   logic [7:0]            dev_waddr_ff;
   logic [7:0]            dev_raddr_ff;
   logic [3:0]            busy_reload_ff;

   phase_type             phase_ff, phase_in;
   sub_type               sub_ff, sub_in;
   logic [3:0]            bit_count_ff, bit_count_in;
   logic [7:0]            shift_ff, shift_in;
   logic [15:0]           bytes_left_ff, bytes_left_in;
   logic [ADDR_WIDTH-1:0] addr_ff, addr_in;
   mode_type              mode_ff, mode_in;
   logic [3:0]            busy_ff, busy_in;
   logic                  nack_ff, nack_in;
   logic                  failed_ff, failed_in;
   logic                  scl_ff, scl_in;
   logic                  sda_ff, sda_in;

   logic                      rsp_valid_ff;
   logic [RSP_DATA_WIDTH-1:0] rsp_data_ff, rsp_data_in;

   logic        req_fire;
   op_type      op;
   logic [15:0] maddr;
   logic [15:0] len;
   logic [7:0]  wdata;
   logic        sda_sample;
   logic [15:0] addr_ext;
   logic [15:0] bytes_dec;
   logic [7:0]  shift_load;
   logic [7:0]  shift_rx;
   logic        receiving;
   logic [7:0]  rb;
   logic        rv;
   logic        dt;
   logic        done;
   logic        st;

   assign req_tready = ~rsp_valid_ff | rsp_tready;
   assign req_fire   = req_tvalid & req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign op         = op_type'(req_tuser);
   assign maddr      = req_tdata[15:0];
   assign len        = req_tdata[31:16];
   assign wdata      = req_tdata[39:32];
   assign sda_sample = req_tdata[40];

   assign addr_ext  = 16'(addr_ff);
   assign bytes_dec = bytes_left_ff - 16'd1;
   assign receiving = (phase_ff == PH_RDATA);
   assign shift_rx  = {shift_ff[6:0], sda_sample};

   always_ff @(posedge clock) begin
      if (reset) begin
         dev_waddr_ff   <= DEV_WRITE_ADDR_RESET;
         dev_raddr_ff   <= DEV_READ_ADDR_RESET;
         busy_reload_ff <= BUSY_RELOAD_RESET;
      end else if (csr_we) begin
         case (csr_index_type'(csr_addr))
            CSR_DEV_WRITE_ADDR: dev_waddr_ff   <= csr_wdata;
            CSR_DEV_READ_ADDR:  dev_raddr_ff   <= csr_wdata;
            CSR_BUSY_RELOAD:    busy_reload_ff <= csr_wdata[3:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      shift_load = shift_ff;
      if (bit_count_ff == 4'd0 && !receiving) begin
         case (phase_ff)
            PH_DEVW: shift_load = dev_waddr_ff;
            PH_AHI:  shift_load = addr_ext[15:8];
            PH_ALO:  shift_load = addr_ext[7:0];
            PH_DEVR: shift_load = dev_raddr_ff;
            default: shift_load = wdata;
         endcase
      end
   end

   always_comb begin
      phase_in      = phase_ff;
      sub_in        = sub_ff;
      bit_count_in  = bit_count_ff;
      shift_in      = shift_ff;
      bytes_left_in = bytes_left_ff;
      addr_in       = addr_ff;
      mode_in       = mode_ff;
      busy_in       = busy_ff;
      nack_in       = nack_ff;
      failed_in     = failed_ff;
      scl_in        = scl_ff;
      sda_in        = sda_ff;
      rb            = 8'd0;
      rv            = 1'b0;
      dt            = 1'b0;
      done          = 1'b0;
      st            = 1'b0;

      if (req_fire) begin
         case (op)
            OP_MS_TICK: begin
               if (busy_ff != 4'd0) busy_in = busy_ff - 4'd1;
            end
            OP_BEGIN_READ, OP_BEGIN_WRITE: begin
               if (phase_ff == PH_IDLE) begin
                  if (len == 16'd0 || busy_ff != 4'd0) begin
                     done = 1'b1;
                     st   = 1'b1;
                  end else begin
                     addr_in       = maddr[ADDR_WIDTH-1:0];
                     bytes_left_in = len;
                     mode_in       = (op == OP_BEGIN_READ) ? MODE_READ : MODE_WRITE;
                     failed_in     = 1'b0;
                     nack_in       = 1'b0;
                     bit_count_in  = 4'd0;
                     sub_in        = SUB_SET_SDA;
                     phase_in      = PH_START_A;
                  end
               end
            end
            default: begin
               case (phase_ff)
                  PH_IDLE: begin
                  end
                  PH_START_A: begin
                     sda_in   = 1'b0;
                     phase_in = PH_START_B;
                  end
                  PH_START_B: begin
                     scl_in       = 1'b0;
                     phase_in     = PH_DEVW;
                     bit_count_in = 4'd0;
                     sub_in       = SUB_SET_SDA;
                  end
                  PH_RST_A: begin
                     sda_in   = 1'b1;
                     phase_in = PH_RST_B;
                  end
                  PH_RST_B: begin
                     scl_in   = 1'b1;
                     phase_in = PH_RST_C;
                  end
                  PH_RST_C: begin
                     sda_in   = 1'b0;
                     phase_in = PH_RST_D;
                  end
                  PH_RST_D: begin
                     scl_in       = 1'b0;
                     phase_in     = PH_DEVR;
                     bit_count_in = 4'd0;
                     sub_in       = SUB_SET_SDA;
                  end
                  PH_STOP_A: begin
                     scl_in   = 1'b1;
                     phase_in = PH_STOP_B;
                  end
                  PH_STOP_B: begin
                     sda_in   = 1'b1;
                     done     = 1'b1;
                     st       = failed_ff;
                     if (!failed_ff && mode_ff == MODE_WRITE) busy_in = busy_reload_ff;
                     mode_in  = MODE_NONE;
                     phase_in = PH_IDLE;
                  end
                  default: begin
                     case (sub_ff)
                        SUB_SET_SDA: begin
                           if (bit_count_ff == 4'd0 && !receiving) begin
                              shift_in = shift_load;
                              if (phase_ff == PH_WDATA) dt = 1'b1;
                           end
                           if (bit_count_ff < BITS_PER_BYTE) begin
                              sda_in = receiving ? 1'b1
                                     : shift_load[3'd7 - bit_count_ff[2:0]];
                           end else begin
                              sda_in = receiving ? (bytes_left_ff <= 16'd1) : 1'b1;
                           end
                           scl_in = 1'b0;
                           sub_in = SUB_SCL_HIGH;
                        end
                        SUB_SCL_HIGH: begin
                           scl_in = 1'b1;
                           if (bit_count_ff < BITS_PER_BYTE && receiving) begin
                              shift_in = shift_rx;
                              if (bit_count_ff == 4'd7) begin
                                 rb = shift_rx;
                                 rv = 1'b1;
                              end
                           end else if (bit_count_ff >= BITS_PER_BYTE && !receiving) begin
                              nack_in = sda_sample;
                           end
                           sub_in = SUB_SCL_LOW;
                        end
                        default: begin
                           scl_in = 1'b0;
                           sub_in = SUB_SET_SDA;
                           if (bit_count_ff < BITS_PER_BYTE) begin
                              bit_count_in = bit_count_ff + 4'd1;
                           end else begin
                              sda_in = 1'b0;
                              case (phase_ff)
                                 PH_DEVW: begin
                                    if (nack_ff) begin
                                       failed_in = 1'b1;
                                       phase_in  = PH_STOP_A;
                                    end else begin
                                       phase_in     = (ADDR_WIDTH > 8) ? PH_AHI : PH_ALO;
                                       bit_count_in = 4'd0;
                                    end
                                 end
                                 PH_AHI: begin
                                    phase_in     = PH_ALO;
                                    bit_count_in = 4'd0;
                                 end
                                 PH_ALO: begin
                                    if (mode_ff == MODE_READ) begin
                                       phase_in = PH_RST_A;
                                    end else begin
                                       phase_in     = PH_WDATA;
                                       bit_count_in = 4'd0;
                                    end
                                 end
                                 PH_DEVR: begin
                                    phase_in     = PH_RDATA;
                                    bit_count_in = 4'd0;
                                 end
                                 PH_RDATA: begin
                                    bytes_left_in = bytes_dec;
                                    if (bytes_dec == 16'd0) begin
                                       phase_in = PH_STOP_A;
                                    end else begin
                                       bit_count_in = 4'd0;
                                    end
                                 end
                                 default: begin
                                    if (nack_ff) begin
                                       failed_in = 1'b1;
                                       phase_in  = PH_STOP_A;
                                    end else begin
                                       bytes_left_in = bytes_dec;
                                       if (bytes_dec == 16'd0) begin
                                          phase_in = PH_STOP_A;
                                       end else begin
                                          bit_count_in = 4'd0;
                                       end
                                    end
                                 end
                              endcase
                           end
                        end
                     endcase
                  end
               endcase
            end
         endcase
      end

      rsp_data_in = {1'b0, (busy_in != 4'd0), st, done, dt, rv, rb, sda_in, scl_in};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         sub_ff        <= SUB_SET_SDA;
         bit_count_ff  <= 4'd0;
         shift_ff      <= 8'd0;
         bytes_left_ff <= 16'd0;
         addr_ff       <= '0;
         mode_ff       <= MODE_NONE;
         busy_ff       <= 4'd0;
         nack_ff       <= 1'b0;
         failed_ff     <= 1'b0;
         scl_ff        <= 1'b1;
         sda_ff        <= 1'b1;
         rsp_valid_ff  <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         sub_ff        <= sub_in;
         bit_count_ff  <= bit_count_in;
         shift_ff      <= shift_in;
         bytes_left_ff <= bytes_left_in;
         addr_ff       <= addr_in;
         mode_ff       <= mode_in;
         busy_ff       <= busy_in;
         nack_ff       <= nack_in;
         failed_ff     <= failed_in;
         scl_ff        <= scl_in;
         sda_ff        <= sda_in;
         if (req_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

[tb/sv/i2c_eeprom_master_sequencer_top_test.sv]
// Self-checking testbench for the I2C EEPROM master sequencer: streamed ticks, predicted lines.
`timescale 1ns / 1ps
module i2c_eeprom_master_sequencer_top_test;
   import iems_pkg::*;

   localparam int         CYCLE_LIMIT = 200000;
   localparam int         HOLD_CYCLES = 300;
   localparam logic [7:0] MSB_MASK    = 8'h80;

   typedef struct packed {
      logic [6:0]  pad;
      logic        sda_in;
      logic [7:0]  write_data;
      logic [15:0] length;
      logic [15:0] mem_address;
   } tick_fields_type;

   typedef struct packed {
      op_type          op;
      tick_fields_type fields;
   } command_type;

   typedef struct packed {
      logic       pad;
      logic       device_busy;
      logic       status;
      logic       done_res;
      logic       data_taken;
      logic       read_valid;
      logic [7:0] read_byte;
      logic       sda_level;
      logic       scl_level;
   } line_state_type;

   logic                      clock;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [REQ_DATA_WIDTH-1:0] req_tdata = '0;
   logic [1:0]                req_tuser = OP_BUS_TICK;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_DATA_WIDTH-1:0] rsp_tdata;
   logic                      csr_we = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0] csr_addr = CSR_DEV_WRITE_ADDR;
   logic [CSR_DATA_WIDTH-1:0] csr_wdata = '0;

   i2c_eeprom_master_sequencer_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   // sequencer shadow state
   phase_type  seq_phase = PH_IDLE;
   sub_type    seq_sub = SUB_SET_SDA;
   mode_type   seq_mode = MODE_NONE;
   logic [3:0] seq_bit = '0;
   logic [7:0] seq_shift = '0;
   logic [15:0] seq_left = '0;
   logic [15:0] seq_addr = '0;
   logic [3:0] busy_left = '0;
   logic       seq_nack = 1'b0;
   logic       seq_failed = 1'b0;
   logic       scl_now = 1'b1;
   logic       sda_now = 1'b1;
   logic [7:0] cfg_write_addr = DEV_WRITE_ADDR_RESET;
   logic [7:0] cfg_read_addr = DEV_READ_ADDR_RESET;
   logic [3:0] cfg_busy_reload = BUSY_RELOAD_RESET;

   command_type    pending_commands[$];
   line_state_type expected_bus_states[$];
   command_type    on_bus;
   command_type    next_cmd;
   line_state_type want;

   int   commands_queued = 0;
   int   beats_checked = 0;
   int   error_count = 0;
   int   transfers_ok = 0;
   int   transfers_failed = 0;
   int   bytes_read = 0;
   int   bytes_written = 0;
   int   cycle_count = 0;
   int   hold_left = 0;
   logic hold_taken = 1'b0;
   logic start_hold = 1'b0;
   logic no_gaps = 1'b0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void open_byte(phase_type next);
      seq_phase = next;
      seq_bit = '0;
      seq_sub = SUB_SET_SDA;
   endfunction

   function automatic line_state_type predict_bus_step(command_type cmd);
      line_state_type r;
      logic           receiving;
      logic [3:0]     b;
      r = '0;
      receiving = (seq_phase == PH_RDATA);
      b = seq_bit;
      case (cmd.op)
         OP_MS_TICK: begin
            if (busy_left != 0) busy_left = busy_left - 1'b1;
         end
         OP_BEGIN_READ, OP_BEGIN_WRITE: begin
            if (seq_phase == PH_IDLE) begin
               if (cmd.fields.length == 0 || busy_left != 0) begin
                  r.done_res = 1'b1;
                  r.status = 1'b1;
               end else begin
                  seq_addr = cmd.fields.mem_address & 16'((32'd1 << ADDR_WIDTH) - 1);
                  seq_left = cmd.fields.length;
                  seq_mode = (cmd.op == OP_BEGIN_READ) ? MODE_READ : MODE_WRITE;
                  seq_failed = 1'b0;
                  seq_nack = 1'b0;
                  seq_bit = '0;
                  seq_sub = SUB_SET_SDA;
                  seq_phase = PH_START_A;
               end
            end
         end
         default: begin
            case (seq_phase)
               PH_IDLE: ;
               PH_START_A: begin sda_now = 1'b0; seq_phase = PH_START_B; end
               PH_START_B: begin scl_now = 1'b0; open_byte(PH_DEVW); end
               PH_RST_A: begin sda_now = 1'b1; seq_phase = PH_RST_B; end
               PH_RST_B: begin scl_now = 1'b1; seq_phase = PH_RST_C; end
               PH_RST_C: begin sda_now = 1'b0; seq_phase = PH_RST_D; end
               PH_RST_D: begin scl_now = 1'b0; open_byte(PH_DEVR); end
               PH_STOP_A: begin scl_now = 1'b1; seq_phase = PH_STOP_B; end
               PH_STOP_B: begin
                  sda_now = 1'b1;
                  r.done_res = 1'b1;
                  r.status = seq_failed;
                  if (!seq_failed && seq_mode == MODE_WRITE) busy_left = cfg_busy_reload;
                  seq_mode = MODE_NONE;
                  seq_phase = PH_IDLE;
               end
               default: begin
                  case (seq_sub)
                     SUB_SET_SDA: begin
                        if (b == 0 && !receiving) begin
                           case (seq_phase)
                              PH_DEVW: seq_shift = cfg_write_addr;
                              PH_AHI: seq_shift = seq_addr[15:8];
                              PH_ALO: seq_shift = seq_addr[7:0];
                              PH_DEVR: seq_shift = cfg_read_addr;
                              default: begin
                                 seq_shift = cmd.fields.write_data;
                                 r.data_taken = 1'b1;
                              end
                           endcase
                        end
                        if (b < BITS_PER_BYTE)
                           sda_now = receiving ? 1'b1 : ((seq_shift & (MSB_MASK >> b)) != 0);
                        else
                           sda_now = receiving ? (seq_left <= 1) : 1'b1;
                        scl_now = 1'b0;
                        seq_sub = SUB_SCL_HIGH;
                     end
                     SUB_SCL_HIGH: begin
                        scl_now = 1'b1;
                        if (b < BITS_PER_BYTE && receiving) begin
                           seq_shift = {seq_shift[6:0], cmd.fields.sda_in};
                           if (b == BITS_PER_BYTE - 1) begin
                              r.read_byte = seq_shift;
                              r.read_valid = 1'b1;
                           end
                        end else if (b >= BITS_PER_BYTE && !receiving) begin
                           seq_nack = cmd.fields.sda_in;
                        end
                        seq_sub = SUB_SCL_LOW;
                     end
                     default: begin
                        scl_now = 1'b0;
                        seq_sub = SUB_SET_SDA;
                        if (b < BITS_PER_BYTE) begin
                           seq_bit = b + 1'b1;
                        end else begin
                           sda_now = 1'b0;
                           case (seq_phase)
                              PH_DEVW: begin
                                 if (seq_nack) begin
                                    seq_failed = 1'b1;
                                    seq_phase = PH_STOP_A;
                                 end else begin
                                    open_byte(ADDR_WIDTH > 8 ? PH_AHI : PH_ALO);
                                 end
                              end
                              PH_AHI: open_byte(PH_ALO);
                              PH_ALO: begin
                                 if (seq_mode == MODE_READ) seq_phase = PH_RST_A;
                                 else open_byte(PH_WDATA);
                              end
                              PH_DEVR: open_byte(PH_RDATA);
                              PH_RDATA: begin
                                 seq_left = seq_left - 1'b1;
                                 if (seq_left == 0) seq_phase = PH_STOP_A;
                                 else open_byte(PH_RDATA);
                              end
                              default: begin
                                 if (seq_nack) begin
                                    seq_failed = 1'b1;
                                    seq_phase = PH_STOP_A;
                                 end else begin
                                    seq_left = seq_left - 1'b1;
                                    if (seq_left == 0) seq_phase = PH_STOP_A;
                                    else open_byte(PH_WDATA);
                                 end
                              end
                           endcase
                        end
                     end
                  endcase
               end
            endcase
         end
      endcase
      r.scl_level = scl_now;
      r.sda_level = sda_now;
      r.device_busy = (busy_left != 0);
      return r;
   endfunction

   // request side: hold the beat until taken, then advance
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            expected_bus_states.push_back(predict_bus_step(on_bus));
         if (!req_tvalid || req_tready) begin
            if (pending_commands.size() != 0 && (no_gaps || $urandom_range(0, 99) >= 10)) begin
               next_cmd = pending_commands.pop_front();
               on_bus <= next_cmd;
               req_tvalid <= 1'b1;
               req_tdata <= next_cmd.fields;
               req_tuser <= next_cmd.op;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // response side: check each beat, drop ready at random or for the long hold
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_left <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_bus_states.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("tb: unexpected response beat %h", rsp_tdata);
            end else begin
               want = expected_bus_states.pop_front();
               beats_checked++;
               if (rsp_tdata !== want) begin
                  error_count++;
                  if (error_count <= 10)
                     $display("tb: mismatch at beat %0d: ", beats_checked,
                              "scl %b/%b sda %b/%b byte %h/%h ",
                              want.scl_level, rsp_tdata[0],
                              want.sda_level, rsp_tdata[1], want.read_byte, rsp_tdata[9:2],
                              "rvalid %b/%b taken %b/%b done %b/%b ",
                              want.read_valid, rsp_tdata[10], want.data_taken, rsp_tdata[11],
                              want.done_res, rsp_tdata[12],
                              "status %b/%b busy %b/%b pad %b/%b (expected/actual)",
                              want.status, rsp_tdata[13],
                              want.device_busy, rsp_tdata[14], want.pad, rsp_tdata[15]);
               end
               if (want.done_res && !want.status) transfers_ok++;
               if (want.done_res && want.status) transfers_failed++;
               if (want.read_valid) bytes_read++;
               if (want.data_taken) bytes_written++;
            end
         end
         if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            rsp_tready <= 1'b0;
         end else if (start_hold && !hold_taken) begin
            hold_left <= HOLD_CYCLES;
            hold_taken <= 1'b1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= no_gaps || ($urandom_range(0, 99) >= 10);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   task automatic add_command(op_type op, logic [15:0] addr, logic [15:0] len,
                              logic [7:0] wd, logic sda);
      command_type c;
      c.op = op;
      c.fields = '{pad: '0, sda_in: sda, write_data: wd, length: len, mem_address: addr};
      pending_commands.push_back(c);
      commands_queued++;
   endtask

   // bus tick, now and then preceded by a millisecond tick or a stray begin
   task automatic add_tick(logic sda);
      if ($urandom_range(0, 19) == 0)
         add_command(OP_MS_TICK, 16'($urandom), 16'($urandom), 8'($urandom), 1'($urandom));
      if ($urandom_range(0, 49) == 0)
         add_command(OP_BEGIN_WRITE, 16'($urandom), 16'($urandom), 8'($urandom),
                     1'($urandom));
      add_command(OP_BUS_TICK, 16'($urandom), 16'($urandom), 8'($urandom), sda);
   endtask

   task automatic add_byte_slots(logic nack);
      for (int j = 0; j <= 8; j++)
         for (int s = 0; s < 3; s++)
            add_tick((j == 8 && s == 1) ? nack : 1'($urandom));
   endtask

   // nack_at: -1 none, 0 device address, k data byte k
   task automatic add_transfer(op_type op, int len, int nack_at);
      add_command(op, 16'($urandom), 16'(len), 8'($urandom), 1'($urandom));
      repeat (2) add_tick(1'($urandom));
      add_byte_slots(nack_at == 0);
      if (nack_at != 0) begin
         repeat (2) add_byte_slots(1'($urandom));
         if (op == OP_BEGIN_READ) begin
            repeat (4) add_tick(1'($urandom));
            add_byte_slots(1'($urandom));
            repeat (len) add_byte_slots(1'($urandom));
         end else begin
            for (int k = 1; k <= len; k++) begin
               add_byte_slots(nack_at == k);
               if (nack_at == k) break;
            end
         end
      end
      repeat (2) add_tick(1'($urandom));
   endtask

   // finish whatever is running, feeding bus ticks with sda high so acknowledges read as nacks
   task automatic drain_to_idle();
      do begin
         while (pending_commands.size() != 0 || req_tvalid || expected_bus_states.size() != 0)
            @(posedge clock);
         if (seq_phase != PH_IDLE) add_command(OP_BUS_TICK, '0, '0, '0, 1'b1);
      end while (pending_commands.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(csr_index_type idx, logic [7:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_DEV_WRITE_ADDR: cfg_write_addr = value;
         CSR_DEV_READ_ADDR: cfg_read_addr = value;
         CSR_BUSY_RELOAD: cfg_busy_reload = value[3:0];
         default: ;
      endcase
   endtask

   task automatic run_random_traffic(int target);
      int first;
      int len;
      int pick;
      first = commands_queued;
      while (commands_queued - first < target) begin
         pick = $urandom_range(0, 9);
         if (pick == 0) begin
            repeat ($urandom_range(5, 15))
               add_command(op_type'($urandom_range(0, 3)), 16'($urandom),
                           16'($urandom_range(0, 3)), 8'($urandom), 1'($urandom));
         end else if (pick <= 4) begin
            add_transfer(OP_BEGIN_READ, $urandom_range(1, 4),
                         ($urandom_range(0, 7) == 0) ? 0 : -1);
         end else if (pick <= 8) begin
            len = $urandom_range(1, 3);
            add_transfer(OP_BEGIN_WRITE, len,
                         ($urandom_range(0, 4) < 3) ? -1 : $urandom_range(0, len));
            repeat ($urandom_range(0, 16))
               add_command(OP_MS_TICK, 16'($urandom), 16'($urandom), 8'($urandom),
                           1'($urandom));
         end else begin
            repeat ($urandom_range(1, 20))
               add_command(OP_MS_TICK, 16'($urandom), 16'($urandom), 8'($urandom),
                           1'($urandom));
         end
      end
      drain_to_idle();
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // idle ticks, zero lengths, begins during a transfer, device address nack
      add_command(OP_BUS_TICK, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b1);
      add_command(OP_MS_TICK, '0, '0, '0, 1'b0);
      add_command(OP_BEGIN_READ, 16'hFFFF, '0, 8'hFF, 1'b1);
      add_command(OP_BEGIN_WRITE, '0, '0, '0, 1'b0);
      add_command(OP_BEGIN_WRITE, 16'hFFFF, 16'd1, 8'h00, 1'b0);
      add_command(OP_BUS_TICK, '0, '0, '0, 1'b0);
      add_command(OP_MS_TICK, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b1);
      add_command(OP_BEGIN_READ, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b1);
      add_command(OP_BEGIN_WRITE, 16'h0000, 16'hFFFF, 8'hFF, 1'b0);
      add_command(OP_BUS_TICK, 16'hFFFF, 16'hFFFF, 8'h00, 1'b1);
      drain_to_idle();
      run_random_traffic(30);

      write_register(CSR_DEV_WRITE_ADDR, 8'h00);
      write_register(CSR_DEV_READ_ADDR, 8'hFF);
      write_register(CSR_BUSY_RELOAD, 8'h00);
      start_hold = 1'b1;
      run_random_traffic(30);

      write_register(CSR_DEV_WRITE_ADDR, 8'hFF);
      write_register(CSR_DEV_READ_ADDR, 8'h00);
      write_register(CSR_BUSY_RELOAD, 8'h0F);
      no_gaps = 1'b1;
      run_random_traffic(30);
      no_gaps = 1'b0;

      write_register(CSR_DEV_WRITE_ADDR, 8'($urandom));
      write_register(CSR_DEV_READ_ADDR, 8'($urandom));
      write_register(CSR_BUSY_RELOAD, 8'($urandom_range(0, 15)));
      run_random_traffic(30);

      $display("Checked %0d response beats over %0d request beats in four register settings.",
               beats_checked, commands_queued);
      $display("Transfers ok %0d, ended in error %0d; bytes read %0d, bytes written %0d.",
               transfers_ok, transfers_failed, bytes_read, bytes_written);
      if (error_count == 0 && expected_bus_states.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
